/* src/arenv_pkg.sv */
// Shared types and constants for the attack/release envelope follower.
// Holds the controller state type, the command and status structs, and
// the register index codes. Depends on nothing.
`default_nettype none

package arenv_pkg;

  // Field widths.
  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned MsW     = 31;
  localparam int unsigned DiffW   = MsW + 2;
  localparam int unsigned ProdW   = DiffW + CoefW;
  localparam int unsigned RootW   = MsW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Square root runs one result bit per step.
  localparam int unsigned SqrtSteps = (MsW + 1) / 2;
  localparam int unsigned SqrtCntW  = $clog2(SqrtSteps);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegAttack  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRelease = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPeak    = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_SQRT,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic square;
    logic diff;
    logic mul;
    logic acc;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sqrt_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

/* src/arenv_ctrl.sv */
// Controller state machine of the envelope follower.
// Sequences the datapath one item at a time; uses arenv_pkg.
`default_nettype none

module arenv_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               peak_mode_i,
  input  wire arenv_pkg::status_t status_i,
  output arenv_pkg::cmd_t         cmd_o,
  output logic                    in_stall_o
);

  arenv_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arenv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      arenv_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = peak_mode_i ? arenv_pkg::ST_DIFF : arenv_pkg::ST_SQUARE;
        end
      end
      arenv_pkg::ST_SQUARE: state_d = arenv_pkg::ST_DIFF;
      arenv_pkg::ST_DIFF:   state_d = arenv_pkg::ST_MUL;
      arenv_pkg::ST_MUL:    state_d = arenv_pkg::ST_ACC;
      arenv_pkg::ST_ACC: begin
        state_d = peak_mode_i ? arenv_pkg::ST_DONE : arenv_pkg::ST_SQRT;
      end
      arenv_pkg::ST_SQRT: begin
        if (status_i.sqrt_last) begin
          state_d = arenv_pkg::ST_DONE;
        end
      end
      arenv_pkg::ST_DONE: begin
        if (!status_i.out_busy) begin
          state_d = arenv_pkg::ST_IDLE;
        end
      end
      default: state_d = arenv_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      arenv_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      arenv_pkg::ST_SQUARE: cmd_o.square    = 1'b1;
      arenv_pkg::ST_DIFF:   cmd_o.diff      = 1'b1;
      arenv_pkg::ST_MUL:    cmd_o.mul       = 1'b1;
      arenv_pkg::ST_ACC:    cmd_o.acc       = 1'b1;
      arenv_pkg::ST_SQRT:   cmd_o.sqrt_step = 1'b1;
      arenv_pkg::ST_DONE:   cmd_o.out_load  = !status_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* src/arenv_dp.sv */
// Datapath of the envelope follower: rectifier, shared multiplier,
// smoother accumulate, bit-serial square root and output register. Uses arenv_pkg.
`default_nettype none

module arenv_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire arenv_pkg::cmd_t                 cmd_i,
  output arenv_pkg::status_t                   status_o,
  input  wire logic                            peak_mode_i,
  input  wire logic [arenv_pkg::CoefW-1:0]     attack_coeff_i,
  input  wire logic [arenv_pkg::CoefW-1:0]     release_coeff_i,
  input  wire logic signed [arenv_pkg::SampleW-1:0] sample_i,
  input  wire logic                            out_stall_i,
  output logic                                 out_valid_o,
  output logic [arenv_pkg::LevelW-1:0]         envelope_o
);

  localparam int unsigned MulW = arenv_pkg::DiffW + arenv_pkg::CoefW + 1;

  logic [arenv_pkg::SampleW-1:0]     mag;
  logic [arenv_pkg::SampleW-1:0]     mag_q;
  logic [arenv_pkg::MsW-1:0]         tgt_q;
  logic signed [arenv_pkg::DiffW-1:0] diff_q;
  logic signed [arenv_pkg::ProdW-1:0] prod_q;
  logic [arenv_pkg::LevelW-1:0]      level_q;
  logic [arenv_pkg::MsW-1:0]         ms_q;
  logic [arenv_pkg::MsW-1:0]         rem_q;
  logic [arenv_pkg::RootW-1:0]       root_q;
  logic [arenv_pkg::RootW-1:0]       bit_q;
  logic [arenv_pkg::SqrtCntW-1:0]    cnt_q;
  logic                              out_valid_q;
  logic [arenv_pkg::LevelW-1:0]      env_q;

  logic [arenv_pkg::CoefW-1:0]       mul_a;
  logic signed [arenv_pkg::DiffW-1:0] mul_b;
  logic signed [MulW-1:0]            mul_p;
  logic [arenv_pkg::MsW-1:0]         prev;
  logic signed [arenv_pkg::DiffW-1:0] sum;
  logic [arenv_pkg::RootW:0]         trial;
  logic                              take;
  logic [arenv_pkg::RootW-1:0]       root_d;

  // Magnitude of the sample; full-scale negative gives 0x8000 exactly.
  assign mag = sample_i[arenv_pkg::SampleW-1] ? (~sample_i + arenv_pkg::SampleW'(1)) : sample_i;

  // Shared multiplier: squares the magnitude or scales the difference.
  // A negative difference means the target rose, so attack applies.
  always_comb begin
    if (cmd_i.square) begin
      mul_a = mag_q;
      mul_b = $signed({{(arenv_pkg::DiffW - arenv_pkg::SampleW){1'b0}}, mag_q});
    end else begin
      mul_a = diff_q[arenv_pkg::DiffW-1] ? attack_coeff_i : release_coeff_i;
      mul_b = diff_q;
    end
  end
  assign mul_p = MulW'($signed({1'b0, mul_a})) * MulW'(mul_b);

  // Previous stored value and the smoother sum target + (a*diff >> 16).
  assign prev = peak_mode_i ?
                {{(arenv_pkg::MsW - arenv_pkg::LevelW){1'b0}}, level_q} : ms_q;
  assign sum  = $signed({2'b00, tgt_q}) + prod_q[arenv_pkg::ProdW-1:arenv_pkg::CoefW];

  // One square root step: trial subtract of root + bit.
  assign trial = {1'b0, root_q} + {1'b0, bit_q};
  assign take  = {1'b0, rem_q} >= trial;
  assign root_d = take ? ((root_q >> 1) + bit_q) : (root_q >> 1);

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mag_q <= mag;
      tgt_q <= {{(arenv_pkg::MsW - arenv_pkg::SampleW){1'b0}}, mag};
    end
    if (cmd_i.square) begin
      tgt_q <= mul_p[arenv_pkg::MsW-1:0];
    end
    if (cmd_i.diff) begin
      diff_q <= $signed({2'b00, prev}) - $signed({2'b00, tgt_q});
    end
    if (cmd_i.mul) begin
      prod_q <= mul_p[arenv_pkg::ProdW-1:0];
    end
    if (cmd_i.acc) begin
      rem_q  <= sum[arenv_pkg::MsW-1:0];
      root_q <= '0;
      bit_q  <= {1'b1, {(arenv_pkg::RootW - 1){1'b0}}} >> (arenv_pkg::RootW % 2 == 1 ? 0 : 1);
    end
    if (cmd_i.sqrt_step) begin
      if (take) begin
        rem_q <= rem_q - trial[arenv_pkg::MsW-1:0];
      end
      root_q <= root_d;
      bit_q  <= bit_q >> 2;
    end
    if (cmd_i.out_load) begin
      env_q <= level_q;
    end
  end

  // Filter state and step counter; reset clears both stored values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      ms_q    <= '0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.acc) begin
        cnt_q <= '0;
        if (peak_mode_i) begin
          level_q <= sum[arenv_pkg::LevelW-1:0];
        end else begin
          ms_q <= sum[arenv_pkg::MsW-1:0];
        end
      end
      if (cmd_i.sqrt_step) begin
        cnt_q <= cnt_q + arenv_pkg::SqrtCntW'(1);
        if (status_o.sqrt_last) begin
          level_q <= root_d[arenv_pkg::LevelW-1:0];
        end
      end
    end
  end

  // Output register; a beat leaves when the sink does not stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.sqrt_last = (cnt_q == arenv_pkg::SqrtCntW'(arenv_pkg::SqrtSteps - 1));
  assign status_o.out_busy  = out_valid_q & out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign envelope_o         = env_q;

endmodule

`default_nettype wire

/* src/attack_release_envelope_follower.sv */
// Attack/release envelope follower, peak or RMS detection, one item at a time.
// Peak mode: difference, multiply, accumulate, then the result beat.
// RMS mode: square, smoother, 16 square root steps from the bit-serial square root.
// In both modes a new item is taken only once the last result is in the output register.
// Reset clears level and mean square; coefficients reset to 0, peak mode to 1.
// Depends on arenv_pkg, arenv_ctrl and arenv_dp.
`default_nettype none

module attack_release_envelope_follower (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [arenv_pkg::SampleW-1:0] sample_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [arenv_pkg::LevelW-1:0]             envelope_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [arenv_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [arenv_pkg::CfgDataW-1:0]      cfg_data_i
);

  logic [arenv_pkg::CoefW-1:0] attack_coeff_q;
  logic [arenv_pkg::CoefW-1:0] release_coeff_q;
  logic                        peak_mode_q;
  arenv_pkg::cmd_t             cmd;
  arenv_pkg::status_t          status;

  // Configuration registers take every write beat.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_coeff_q  <= '0;
      release_coeff_q <= '0;
      peak_mode_q     <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        arenv_pkg::RegAttack:  attack_coeff_q  <= cfg_data_i[arenv_pkg::CoefW-1:0];
        arenv_pkg::RegRelease: release_coeff_q <= cfg_data_i[arenv_pkg::CoefW-1:0];
        arenv_pkg::RegPeak:    peak_mode_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Controller.
  arenv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .peak_mode_i (peak_mode_q),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  // Datapath.
  arenv_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .peak_mode_i     (peak_mode_q),
    .attack_coeff_i  (attack_coeff_q),
    .release_coeff_i (release_coeff_q),
    .sample_i        (sample_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .envelope_o      (envelope_o)
  );

  // An accepted beat keeps the input stalled while the item is worked on.
  a_accept_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a beat");

  // The envelope never exceeds full scale.
  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (envelope_o <= 16'h8000))
    else $error("envelope above full scale");

  // A new result is loaded only while the input side is stalled.
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> in_stall_o)
    else $error("result loaded while input side was open");

endmodule

`default_nettype wire
